// ----- rtl/gmbc_pkg.sv -----
// Shared types and constants for the grid minimum black cell path block.
// No dependencies; imported by the controller, datapath and top level.
package gmbc_pkg;

    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = 7;
    localparam int CELL_N   = MAX_SIDE * MAX_SIDE;
    localparam int CELL_AW  = $clog2(CELL_N);
    localparam int DIST_W   = 13;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        RS_LEFT  = 3'd0,
        RS_RIGHT = 3'd1,
        RS_UP    = 3'd2,
        RS_DOWN  = 3'd3,
        RS_SELF  = 3'd4,
        RS_LAST  = 3'd5
    } rsel_t;

    typedef struct packed {
        logic  load_wr;
        logic  idx_rst;
        logic  idx_adv;
        logic  init_wr;
        logic  best_clr;
        logic  fold_en;
        rsel_t fold_sel;
        rsel_t rd_sel;
        logic  upd;
        logic  chg_clr;
        logic  res_cap;
    } cmd_t;

    typedef struct packed {
        logic ld_last;
        logic idx_last;
        logic changed;
    } sts_t;

endpackage

// ----- rtl/gmbc_ctrl.sv -----
// Sequencer for loading, distance init, relaxation sweeps and result hand-off.
// Depends on gmbc_pkg; drives gmbc_datapath through cmd_t.
module gmbc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  gmbc_pkg::sts_t sts,
    output gmbc_pkg::cmd_t cmd
);
    import gmbc_pkg::*;

    typedef enum logic [9:0] {
        ST_LOAD     = 10'b00_0000_0001,
        ST_INIT     = 10'b00_0000_0010,
        ST_RD_L     = 10'b00_0000_0100,
        ST_RD_R     = 10'b00_0000_1000,
        ST_RD_U     = 10'b00_0001_0000,
        ST_RD_D     = 10'b00_0010_0000,
        ST_RD_S     = 10'b00_0100_0000,
        ST_UPD      = 10'b00_1000_0000,
        ST_RES_RD   = 10'b01_0000_0000,
        ST_RES_WAIT = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.rd_sel     = RS_SELF;
        cmd.fold_sel   = RS_SELF;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (sts.ld_last)
                    begin
                        cmd.idx_rst = 1'b1;
                        state_next  = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.idx_rst = 1'b1;
                    cmd.chg_clr = 1'b1;
                    state_next  = ST_RD_L;
                end
                else
                begin
                    cmd.idx_adv = 1'b1;
                end
            end
            ST_RD_L:
            begin
                cmd.rd_sel   = RS_LEFT;
                cmd.best_clr = 1'b1;
                state_next   = ST_RD_R;
            end
            ST_RD_R:
            begin
                cmd.rd_sel   = RS_RIGHT;
                cmd.fold_en  = 1'b1;
                cmd.fold_sel = RS_LEFT;
                state_next   = ST_RD_U;
            end
            ST_RD_U:
            begin
                cmd.rd_sel   = RS_UP;
                cmd.fold_en  = 1'b1;
                cmd.fold_sel = RS_RIGHT;
                state_next   = ST_RD_D;
            end
            ST_RD_D:
            begin
                cmd.rd_sel   = RS_DOWN;
                cmd.fold_en  = 1'b1;
                cmd.fold_sel = RS_UP;
                state_next   = ST_RD_S;
            end
            ST_RD_S:
            begin
                cmd.rd_sel   = RS_SELF;
                cmd.fold_en  = 1'b1;
                cmd.fold_sel = RS_DOWN;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.idx_rst = 1'b1;
                    cmd.chg_clr = 1'b1;
                    // the update this cycle may still set changed
                    state_next  = sts.changed ? ST_RD_L : ST_RES_RD;
                end
                else
                begin
                    cmd.idx_adv = 1'b1;
                    state_next  = ST_RD_L;
                end
            end
            ST_RES_RD:
            begin
                cmd.rd_sel = RS_LAST;
                state_next = ST_RES_WAIT;
            end
            ST_RES_WAIT:
            begin
                cmd.rd_sel = RS_LAST;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_cap    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/gmbc_datapath.sv -----
// Cell map, distance store, sweep counters and relaxation compare.
// Depends on gmbc_pkg; commanded by gmbc_ctrl.
module gmbc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [gmbc_pkg::SIDE_W-1:0]   grid_side,
    input  logic                          cell_is_black,
    input  gmbc_pkg::cmd_t                cmd,
    output gmbc_pkg::sts_t                sts,
    output logic [gmbc_pkg::DIST_W-1:0]   min_black_cells
);
    import gmbc_pkg::*;

    logic                cell_map [CELL_N];
    logic [DIST_W-1:0]   dist_mem [CELL_N];

    logic [SIDE_W-1:0]   side_reg;
    logic [DIST_W-1:0]   count_reg;
    logic [CELL_AW-1:0]  idx_reg;
    logic [SIDE_W-1:0]   row_reg;
    logic [SIDE_W-1:0]   col_reg;
    logic [DIST_W-1:0]   best_reg;
    logic                chg_reg;
    logic [DIST_W-1:0]   rd_q_reg;
    logic                cb_q_reg;
    logic [DIST_W-1:0]   out_reg;

    logic [SIDE_W-1:0]   side;
    logic [2*SIDE_W-1:0] cells_w;
    logic [DIST_W-1:0]   cells;
    logic [CELL_AW-1:0]  last_idx;
    logic [CELL_AW-1:0]  side_ext;
    logic [CELL_AW-1:0]  rd_addr;
    logic                v_left, v_right, v_up, v_down, fold_ok;
    logic [DIST_W-1:0]   cand;
    logic                do_wr;

    always_comb
    begin
        if (side_reg == '0)
            side = SIDE_W'(1);
        else if (side_reg > SIDE_W'(MAX_SIDE))
            side = SIDE_W'(MAX_SIDE);
        else
            side = side_reg;
    end

    assign cells_w  = side * side;
    assign cells    = cells_w[DIST_W-1:0];
    assign last_idx = CELL_AW'(cells - DIST_W'(1));
    assign side_ext = CELL_AW'(side);

    assign v_left  = (col_reg != '0);
    assign v_right = (col_reg + SIDE_W'(1) != side);
    assign v_up    = (row_reg != '0);
    assign v_down  = (row_reg + SIDE_W'(1) != side);

    always_comb
    begin
        case (cmd.rd_sel)
            RS_LEFT:  rd_addr = idx_reg - CELL_AW'(1);
            RS_RIGHT: rd_addr = idx_reg + CELL_AW'(1);
            RS_UP:    rd_addr = idx_reg - side_ext;
            RS_DOWN:  rd_addr = idx_reg + side_ext;
            RS_LAST:  rd_addr = last_idx;
            default:  rd_addr = idx_reg;
        endcase
        case (cmd.fold_sel)
            RS_LEFT:  fold_ok = v_left;
            RS_RIGHT: fold_ok = v_right;
            RS_UP:    fold_ok = v_up;
            RS_DOWN:  fold_ok = v_down;
            default:  fold_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        if (idx_reg == '0)
            cand = DIST_W'(cb_q_reg);
        else if (best_reg == DIST_MAX)
            cand = DIST_MAX;
        else
            cand = best_reg + DIST_W'(cb_q_reg);
    end

    assign do_wr = cmd.upd && (cand < rd_q_reg);

    assign sts.ld_last  = (count_reg == cells - DIST_W'(1));
    assign sts.idx_last = (idx_reg == last_idx);
    assign sts.changed  = chg_reg || do_wr;

    assign min_black_cells = out_reg;

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            cell_map[count_reg[CELL_AW-1:0]] <= cell_is_black;
        cb_q_reg <= cell_map[idx_reg];
        if (cmd.init_wr)
            dist_mem[idx_reg] <= DIST_MAX;
        else if (do_wr)
            dist_mem[idx_reg] <= cand;
        rd_q_reg <= dist_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.best_clr)
            best_reg <= DIST_MAX;
        else if (cmd.fold_en && fold_ok && (rd_q_reg < best_reg))
            best_reg <= rd_q_reg;
        if (cmd.res_cap)
            out_reg <= rd_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= SIDE_W'(8);
            count_reg <= '0;
            idx_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            chg_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                side_reg  <= grid_side;
                count_reg <= '0;
            end
            else if (cmd.load_wr)
            begin
                count_reg <= sts.ld_last ? '0 : count_reg + DIST_W'(1);
            end

            if (cmd.idx_rst)
            begin
                idx_reg <= '0;
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (cmd.idx_adv)
            begin
                idx_reg <= idx_reg + CELL_AW'(1);
                if (!v_right)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + SIDE_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + SIDE_W'(1);
                end
            end

            if (cmd.chg_clr)
                chg_reg <= 1'b0;
            else if (do_wr)
                chg_reg <= 1'b1;
        end
    end

endmodule

// ----- rtl/grid_min_black_cell_path_core.sv -----
// Top level of the grid minimum black cell path block.
// Depends on gmbc_pkg, gmbc_ctrl and gmbc_datapath.
//
// Cells load one per cycle in row-major order. Then the distance store is set
// to the maximum and sweeps run: each cell reads its left, right, up, down and
// own distance, then updates; sweeps repeat until one changes nothing, and the
// result is read from the last cell. The store has one write and one
// registered read port, one neighbor read per cycle. Input is not taken during
// compute; a pending result does not block loading the next grid.
module grid_min_black_cell_path_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gmbc_pkg::SIDE_W-1:0]   grid_side,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cell_is_black,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gmbc_pkg::DIST_W-1:0]   min_black_cells
);
    import gmbc_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_rdy;

    assign cfg_ready = 1'b1;
    assign in_ready  = in_rdy;

    gmbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_rdy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gmbc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .grid_side       (grid_side),
        .cell_is_black   (cell_is_black),
        .cmd             (cmd),
        .sts             (sts),
        .min_black_cells (min_black_cells)
    );

endmodule
